FILE: hw/rtl/kmce_pkg.sv
package kmce_pkg;

  localparam int unsigned KmceColumns = 8;
  localparam int unsigned KmceRows    = 8;

  // Row levels carried by one sample
  localparam int unsigned LevelBits = 8;

  typedef struct packed {
    logic [2:0] column_index;
    logic [7:0] row_levels;
  } in_t;

  typedef struct packed {
    logic [6:0] event_code;
    logic       last_event;
  } out_t;

endpackage

FILE: hw/rtl/key_matrix_change_encoder.sv
// Channel | Ports                                 | Transfer when
// --------+---------------------------------------+---------------------------
// sample  | in_valid_i, in_stall_o, in_data_i     | in_valid_i && !in_stall_o
// event   | out_valid_o, out_stall_i, out_data_o  | out_valid_o && !out_stall_i
//
// The key-state read is registered; the event register then sends one event
// per cycle while out_stall_i is low, one event for each key a sample changes
// (at most 8). Samples that change nothing transfer at one per cycle. Reset
// marks every entry unread, which reads as all keys pressed, so no clearing
// pass is needed. An event stall holds the event register and, once the
// pending sample is blocked, the input.
module key_matrix_change_encoder #(
  parameter int unsigned COLUMNS = kmce_pkg::KmceColumns,
  parameter int unsigned ROWS    = kmce_pkg::KmceRows
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kmce_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output kmce_pkg::out_t out_data_o
);
  import kmce_pkg::*;

  // Rows actually scanned
  localparam int unsigned ScanRows = (ROWS < LevelBits) ? ROWS : LevelBits;
  localparam int unsigned IdxW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned CodeW    = 10;

  logic [ScanRows-1:0] mem_q [COLUMNS];
  logic [COLUMNS-1:0]  written_q;

  logic                b_valid_q;
  logic                b_ok_q;
  logic [2:0]          b_col_q;
  logic [ScanRows-1:0] b_lvl_q;
  logic [ScanRows-1:0] rd_q;
  logic                rd_written_q;
  logic                fwd_q;
  logic [ScanRows-1:0] fwd_data_q;

  logic [ScanRows-1:0] em_mask_q;
  logic [ScanRows-1:0] em_state_q;
  logic [2:0]          em_col_q;

  logic                accept;
  logic [IdxW-1:0]     in_idx;
  logic [IdxW-1:0]     b_idx;
  logic                in_ok;
  logic [ScanRows-1:0] stored;
  logic [ScanRows-1:0] new_state;
  logic [ScanRows-1:0] chg;
  logic                b_move;
  logic                out_xfer;
  logic [ScanRows-1:0] em_rest;
  logic                em_last;
  logic                em_free;
  logic [2:0]          row_sel;
  logic                row_pressed;
  logic [CodeW-1:0]    code;

  assign in_idx = IdxW'(in_data_i.column_index);
  assign b_idx  = IdxW'(b_col_q);
  assign in_ok  = (int'(in_data_i.column_index) < COLUMNS);

  // Latest value of the entry: forwarded write, memory, or reset state
  always_comb begin
    if (fwd_q) begin
      stored = fwd_data_q;
    end else if (rd_written_q) begin
      stored = rd_q;
    end else begin
      stored = '1;
    end
  end

  assign new_state = ~b_lvl_q;
  assign chg       = (stored ^ new_state) & {ScanRows{b_ok_q}};

  assign out_valid_o = |em_mask_q;
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign em_rest     = em_mask_q & (em_mask_q - 1'b1);
  assign em_last     = (em_rest == '0);
  assign em_free     = !out_valid_o || (out_xfer && em_last);

  assign b_move     = b_valid_q && ((chg == '0) || em_free);
  assign in_stall_o = b_valid_q && !b_move;
  assign accept     = in_valid_i && !in_stall_o;

  // Lowest pending row goes first
  always_comb begin
    row_sel     = '0;
    row_pressed = 1'b0;
    for (int r = ScanRows - 1; r >= 0; r--) begin
      if (em_mask_q[r]) begin
        row_sel     = 3'(r);
        row_pressed = em_state_q[r];
      end
    end
  end

  always_comb begin
    code = CodeW'(row_sel) + CodeW'(em_col_q) * CodeW'(ROWS);
    if (row_pressed) begin
      code = code + CodeW'(COLUMNS * ROWS);
    end
  end

  assign out_data_o.event_code = code[6:0];
  assign out_data_o.last_event = em_last;

  // Key-state memory: write back on hand-off, read on transfer
  always_ff @(posedge clk_i) begin
    if (b_move && b_ok_q) begin
      mem_q[b_idx] <= new_state;
    end
    if (accept) begin
      rd_q <= mem_q[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      b_valid_q    <= 1'b0;
      em_mask_q    <= '0;
      b_ok_q       <= 1'b0;
      rd_written_q <= 1'b0;
      fwd_q        <= 1'b0;
    end else begin
      if (b_move && b_ok_q) begin
        written_q[b_idx] <= 1'b1;
      end
      if (b_move || accept) begin
        b_valid_q <= accept;
      end
      if (accept) begin
        b_ok_q       <= in_ok;
        rd_written_q <= written_q[in_idx];
        fwd_q        <= b_move && b_ok_q && (b_idx == in_idx);
      end
      if (b_move && (chg != '0)) begin
        em_mask_q <= chg;
      end else if (out_xfer) begin
        em_mask_q <= em_rest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q    <= in_data_i.column_index;
      b_lvl_q    <= in_data_i.row_levels[ScanRows-1:0];
      fwd_data_q <= new_state;
    end
    if (b_move && (chg != '0)) begin
      em_state_q <= new_state;
      em_col_q   <= b_col_q;
    end
  end

endmodule

FILE: tb/key_matrix_change_encoder_tb.sv
module key_matrix_change_encoder_tb;
  import kmce_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  key_matrix_change_encoder u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Pressed bit per key, bit r of entry c is row r of column c
  logic [7:0] key_state [KmceColumns];
  out_t       pending_events [$];
  int         error_count;

  // Sender burst shaping
  bit sender_gaps;
  int burst_left;

  // Receiver stall shaping
  int         stall_mode;
  int         stall_phase_left;
  logic [7:0] stall_pattern;
  int         stall_pos;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // Work out the events one accepted sample causes and update the key image
  function automatic void predict_scan(input in_t sample);
    int   n_events;
    out_t ev;
    logic now_pressed;
    int   code;
    n_events = 0;
    if (sample.column_index >= KmceColumns) return;
    for (int r = 0; r < KmceRows && r < LevelBits; r++) begin
      now_pressed = ~sample.row_levels[r];
      if (key_state[sample.column_index][r] != now_pressed) begin
        key_state[sample.column_index][r] = now_pressed;
        code = r + sample.column_index * KmceRows;
        if (now_pressed) code += KmceColumns * KmceRows;
        ev.event_code = code[6:0];
        ev.last_event = 1'b0;
        pending_events.push_back(ev);
        n_events++;
      end
    end
    if (n_events > 0) pending_events[pending_events.size() - 1].last_event = 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(input logic [2:0] column, input logic [7:0] levels);
    in_t sample;
    sample.column_index = column;
    sample.row_levels   = levels;
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_scan(sample);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  // Receiver stall pattern: free running, random, or a rotating pattern
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_phase_left == 0) begin
        stall_mode       = $urandom_range(0, 3);
        stall_phase_left = $urandom_range(20, 80);
        stall_pattern    = 8'($urandom_range(0, 255));
      end else begin
        stall_phase_left--;
      end
      stall_pos = (stall_pos + 1) % 8;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= stall_pattern[stall_pos];
      endcase
    end
  end

  always @(posedge clk) begin : event_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event code=%0d last=%0b",
                                  out_data.event_code, out_data.last_event));
      end else begin
        want = pending_events.pop_front();
        if (out_data.event_code !== want.event_code)
          report_mismatch($sformatf("event_code got %0d want %0d",
                                    out_data.event_code, want.event_code));
        if (out_data.last_event !== want.last_event)
          report_mismatch($sformatf("last_event got %0b want %0b (code %0d)",
                                    out_data.last_event, want.last_event,
                                    want.event_code));
      end
    end
  end

  // Every key starts pressed, so keys that are up report releases
  task automatic test_first_scan_releases();
    send_sample(3'd0, 8'hFF);
    send_sample(3'd7, 8'hFF);
    send_sample(3'd0, 8'hFF);
    send_sample(3'd6, 8'h00);
  endtask

  task automatic test_code_extremes();
    send_sample(3'd7, 8'h00);
    send_sample(3'd0, 8'h00);
    send_sample(3'd0, 8'h7F);
    send_sample(3'd0, 8'hFE);
    send_sample(3'd7, 8'h80);
    send_sample(3'd7, 8'h01);
  endtask

  task automatic test_row_patterns();
    send_sample(3'd3, 8'hAA);
    send_sample(3'd3, 8'h55);
    send_sample(3'd3, 8'h55);
    send_sample(3'd5, 8'h0F);
    send_sample(3'd5, 8'hF0);
    send_sample(3'd1, 8'h01);
    send_sample(3'd2, 8'h80);
    send_sample(3'd4, 8'hFF);
    send_sample(3'd4, 8'hFF);
  endtask

  // Mostly a column-by-column scan with a few keys changing, some noise
  task automatic test_random_scan(input int count);
    logic [2:0] column;
    logic [7:0] levels;
    int         kind;
    int         flips;
    column = 3'd0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) sender_gaps = ~sender_gaps;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        levels = ~key_state[column];
        flips  = $urandom_range(0, 3);
        repeat (flips) levels[$urandom_range(0, 7)] ^= 1'b1;
        send_sample(column, levels);
        column = column + 3'd1;
      end else if (kind == 8) begin
        send_sample(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else begin
        send_sample(column, ~key_state[column]);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    error_count = 0;
    sender_gaps = 1'b1;
    burst_left  = 0;
    stall_mode  = 0;
    stall_phase_left = 0;
    stall_pattern    = '0;
    stall_pos        = 0;
    for (int c = 0; c < KmceColumns; c++) key_state[c] = '1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_first_scan_releases();
    test_code_extremes();
    test_row_patterns();
    test_random_scan(150);
    wait_drained();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
